// ===== rtl/pat2d_pkg.sv =====
// ---------------------------------------------------------------------------
// pat2d_pkg: shared types, constants and functions of the 2D point transform.
// Holds the register indexes, the payload records, the CORDIC arctangent
// table and the saturation helper used by every pipeline section.
// ---------------------------------------------------------------------------
package pat2d_pkg;

    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_ANGLE_BITS = 16;
    localparam int CORDIC_STEPS   = 30;
    localparam int ROT_FRAC_BITS  = 30;

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_SCALE_X  = 3'd2,
        CFG_SCALE_Y  = 3'd3,
        CFG_ROTATION = 3'd4,
        CFG_SHIFT_X  = 3'd5,
        CFG_SHIFT_Y  = 3'd6
    } cfg_idx_t;

    typedef logic signed [67:0] wide_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               sat;
    } pt_t;

    typedef struct packed {
        logic signed [31:0] cos_val;
        logic signed [31:0] sin_val;
    } trig_t;

    typedef struct packed {
        logic               clip;
        logic signed [31:0] val;
    } sat_t;

    function automatic sat_t sat32(input wide_t v);
        sat_t r;
        if (v > wide_t'(32'sh7FFFFFFF))
        begin
            r.clip = 1'b1;
            r.val  = 32'sh7FFFFFFF;
        end
        else if (v < wide_t'(-33'sh080000000))
        begin
            r.clip = 1'b1;
            r.val  = 32'sh80000000;
        end
        else
        begin
            r.clip = 1'b0;
            r.val  = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [33:0] atan_step(input logic [4:0] i);
        logic signed [33:0] a;
        case (i)
            5'd0:    a = 34'sd536870912;
            5'd1:    a = 34'sd316933406;
            5'd2:    a = 34'sd167458907;
            5'd3:    a = 34'sd85004756;
            5'd4:    a = 34'sd42667331;
            5'd5:    a = 34'sd21354465;
            5'd6:    a = 34'sd10679838;
            5'd7:    a = 34'sd5340245;
            5'd8:    a = 34'sd2670163;
            5'd9:    a = 34'sd1335088;
            5'd10:   a = 34'sd667544;
            5'd11:   a = 34'sd333772;
            5'd12:   a = 34'sd166886;
            5'd13:   a = 34'sd83443;
            5'd14:   a = 34'sd41722;
            5'd15:   a = 34'sd20861;
            5'd16:   a = 34'sd10430;
            5'd17:   a = 34'sd5215;
            5'd18:   a = 34'sd2608;
            5'd19:   a = 34'sd1304;
            5'd20:   a = 34'sd652;
            5'd21:   a = 34'sd326;
            5'd22:   a = 34'sd163;
            5'd23:   a = 34'sd81;
            5'd24:   a = 34'sd41;
            5'd25:   a = 34'sd20;
            5'd26:   a = 34'sd10;
            5'd27:   a = 34'sd5;
            5'd28:   a = 34'sd3;
            5'd29:   a = 34'sd1;
            default: a = 34'sd0;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/point_affine_transform_2d.sv =====
// ---------------------------------------------------------------------------
// point_affine_transform_2d: scale, rotate and translate one 2D point.
// A request is taken on a rising edge with start high and busy low and
// carries point_x and point_y in signed fixed point. Each point is scaled
// about the configured origin, rotated about it and then shifted; every
// step saturates. The result shows on result_x, result_y and saturated for
// exactly one cycle with done high. While busy is low a new request can be
// taken in every cycle, so the rate is one point per clock; the datapath
// has eight register stages. Registers are written through cfg_valid,
// cfg_ready, cfg_index and cfg_data; the user must write them only while no
// request is in flight, which the block itself does not enforce. A write of
// the rotation angle starts the sine and cosine unit, which holds busy high
// until the new values are stored; other writes take effect at once.
// Writes to an unknown index are dropped. Reset restores the origin to zero,
// both scales to one, the angle and the shifts to zero, and empties the
// pipeline. The receiver cannot stall.
// ---------------------------------------------------------------------------
module point_affine_transform_2d #(
    parameter int FRAC_BITS  = pat2d_pkg::DEF_FRAC_BITS,
    parameter int ANGLE_BITS = pat2d_pkg::DEF_ANGLE_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  point_x,
    input  logic signed [31:0]  point_y,
    output logic                done,
    output logic signed [31:0]  result_x,
    output logic signed [31:0]  result_y,
    output logic                saturated,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import pat2d_pkg::*;

    localparam logic [31:0] ANG_MASK = (32'd1 << ANGLE_BITS) - 32'd1;

    logic signed [31:0] origin_x_reg, origin_y_reg;
    logic signed [31:0] scale_x_reg, scale_y_reg;
    logic signed [31:0] shift_x_reg, shift_y_reg;
    logic [15:0]        rotation_reg;
    logic               load_reg, load_next;

    logic               cfg_we;
    logic [31:0]        angle_word;
    logic               rot_en;
    logic               cordic_busy;
    trig_t              trig;

    logic               scale_valid, rot_valid;
    pt_t                scale_pt, rot_pt;

    logic               done_reg;
    pt_t                res_reg, res_next;
    sat_t               sat_x, sat_y;

    assign cfg_ready  = 1'b1;
    assign cfg_we     = cfg_valid & cfg_ready;
    assign angle_word = (32'(rotation_reg) & ANG_MASK) << (32 - ANGLE_BITS);
    assign rot_en     = |angle_word;
    assign load_next  = cfg_we && (cfg_index == CFG_ROTATION);
    assign busy       = load_reg | cordic_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            scale_x_reg  <= 32'sd1 <<< FRAC_BITS;
            scale_y_reg  <= 32'sd1 <<< FRAC_BITS;
            rotation_reg <= '0;
            shift_x_reg  <= '0;
            shift_y_reg  <= '0;
            load_reg     <= 1'b0;
        end
        else
        begin
            load_reg <= load_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ORIGIN_X: origin_x_reg <= cfg_data;
                    CFG_ORIGIN_Y: origin_y_reg <= cfg_data;
                    CFG_SCALE_X:  scale_x_reg  <= cfg_data;
                    CFG_SCALE_Y:  scale_y_reg  <= cfg_data;
                    CFG_ROTATION: rotation_reg <= cfg_data[15:0];
                    CFG_SHIFT_X:  shift_x_reg  <= cfg_data;
                    CFG_SHIFT_Y:  shift_y_reg  <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    pat2d_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load_reg),
        .angle (angle_word),
        .busy  (cordic_busy),
        .trig  (trig)
    );

    pat2d_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .px        (point_x),
        .py        (point_y),
        .ox        (origin_x_reg),
        .oy        (origin_y_reg),
        .sx        (scale_x_reg),
        .sy        (scale_y_reg),
        .out_valid (scale_valid),
        .out_pt    (scale_pt)
    );

    pat2d_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scale_valid),
        .in_pt     (scale_pt),
        .ox        (origin_x_reg),
        .oy        (origin_y_reg),
        .trig      (trig),
        .rot_en    (rot_en),
        .out_valid (rot_valid),
        .out_pt    (rot_pt)
    );

    always_comb
    begin
        sat_x        = sat32(wide_t'(rot_pt.x) + wide_t'(shift_x_reg));
        sat_y        = sat32(wide_t'(rot_pt.y) + wide_t'(shift_y_reg));
        res_next.x   = sat_x.val;
        res_next.y   = sat_y.val;
        res_next.sat = rot_pt.sat | sat_x.clip | sat_y.clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= rot_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done      = done_reg;
    assign result_x  = res_reg.x;
    assign result_y  = res_reg.y;
    assign saturated = res_reg.sat;

endmodule

// ===== rtl/pat2d_cordic.sv =====
// ---------------------------------------------------------------------------
// pat2d_cordic: iterative sine and cosine of the configured rotation angle.
// One CORDIC micro-rotation per cycle, then a final step folds the quadrant
// back in. The results stay valid until the next load.
// ---------------------------------------------------------------------------
module pat2d_cordic (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [31:0]         angle,
    output logic                busy,
    output pat2d_pkg::trig_t    trig
);
    import pat2d_pkg::*;

    localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

    logic               run_reg, run_next;
    logic               fin_reg, fin_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               flip_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    trig_t              trig_reg;

    logic               flip;
    logic [31:0]        angle_adj;
    logic signed [33:0] x_sh, y_sh, x_step, y_step, z_step;

    always_comb
    begin
        flip      = angle[31] ^ angle[30];
        angle_adj = {angle[31] ^ flip, angle[30:0]};
        x_sh      = x_reg >>> cnt_reg;
        y_sh      = y_reg >>> cnt_reg;
        if (!z_reg[33])
        begin
            x_step = x_reg - y_sh;
            y_step = y_reg + x_sh;
            z_step = z_reg - atan_step(cnt_reg);
        end
        else
        begin
            x_step = x_reg + y_sh;
            y_step = y_reg - x_sh;
            z_step = z_reg + atan_step(cnt_reg);
        end
    end

    always_comb
    begin
        run_next = run_reg;
        fin_next = 1'b0;
        cnt_next = cnt_reg;
        if (load)
        begin
            run_next = 1'b1;
            cnt_next = '0;
        end
        else if (run_reg)
        begin
            if (cnt_reg == LAST_STEP)
            begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            fin_reg <= fin_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flip_reg <= flip;
            x_reg    <= CORDIC_X0;
            y_reg    <= '0;
            z_reg    <= 34'($signed(angle_adj));
        end
        else if (run_reg)
        begin
            x_reg <= x_step;
            y_reg <= y_step;
            z_reg <= z_step;
        end
        if (fin_reg)
        begin
            trig_reg.cos_val <= flip_reg ? 32'(-x_reg) : 32'(x_reg);
            trig_reg.sin_val <= flip_reg ? 32'(-y_reg) : 32'(y_reg);
        end
    end

    assign busy = run_reg | fin_reg;
    assign trig = trig_reg;

endmodule

// ===== rtl/pat2d_scale.sv =====
// ---------------------------------------------------------------------------
// pat2d_scale: scaling about the origin, three pipeline stages.
// Stage one forms the offset from the origin, stage two multiplies by the
// scale factor, stage three rounds, adds the origin back and saturates.
// ---------------------------------------------------------------------------
module pat2d_scale #(
    parameter int FRAC_BITS = pat2d_pkg::DEF_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [31:0]  px,
    input  logic signed [31:0]  py,
    input  logic signed [31:0]  ox,
    input  logic signed [31:0]  oy,
    input  logic signed [31:0]  sx,
    input  logic signed [31:0]  sy,
    output logic                out_valid,
    output pat2d_pkg::pt_t      out_pt
);
    import pat2d_pkg::*;

    localparam wide_t HALF = wide_t'(1) <<< (FRAC_BITS - 1);

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic signed [64:0] prx_reg, pry_reg;
    pt_t                pt_reg, pt_next;

    wide_t              wx, wy;
    sat_t               sat_x, sat_y;

    always_comb
    begin
        wx          = (wide_t'(prx_reg) + HALF) >>> FRAC_BITS;
        wy          = (wide_t'(pry_reg) + HALF) >>> FRAC_BITS;
        sat_x       = sat32(wx + wide_t'(ox));
        sat_y       = sat32(wy + wide_t'(oy));
        pt_next.x   = sat_x.val;
        pt_next.y   = sat_y.val;
        pt_next.sat = sat_x.clip | sat_y.clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= 33'(px) - 33'(ox);
        dy_reg  <= 33'(py) - 33'(oy);
        prx_reg <= dx_reg * sx;
        pry_reg <= dy_reg * sy;
        pt_reg  <= pt_next;
    end

    assign out_valid = v3_reg;
    assign out_pt    = pt_reg;

endmodule

// ===== rtl/pat2d_rotate.sv =====
// ---------------------------------------------------------------------------
// pat2d_rotate: rotation about the origin, four pipeline stages.
// Offset, four products with the stored cosine and sine, sum and difference,
// then rounding, origin add and saturation. A zero angle passes the point.
// ---------------------------------------------------------------------------
module pat2d_rotate (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  pat2d_pkg::pt_t      in_pt,
    input  logic signed [31:0]  ox,
    input  logic signed [31:0]  oy,
    input  pat2d_pkg::trig_t    trig,
    input  logic                rot_en,
    output logic                out_valid,
    output pat2d_pkg::pt_t      out_pt
);
    import pat2d_pkg::*;

    localparam wide_t ROUND = wide_t'(1) <<< (ROT_FRAC_BITS - 1);

    logic               v4_reg, v5_reg, v6_reg, v7_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic signed [64:0] xc_reg, ys_reg, xs_reg, yc_reg;
    logic signed [65:0] sumx_reg, sumy_reg;
    pt_t                pt4_reg, pt5_reg, pt6_reg, pt7_reg, pt_next;

    wide_t              wx, wy;
    sat_t               sat_x, sat_y;

    always_comb
    begin
        wx    = (wide_t'(sumx_reg) + ROUND) >>> ROT_FRAC_BITS;
        wy    = (wide_t'(sumy_reg) + ROUND) >>> ROT_FRAC_BITS;
        sat_x = sat32(wx + wide_t'(ox));
        sat_y = sat32(wy + wide_t'(oy));
        if (rot_en)
        begin
            pt_next.x   = sat_x.val;
            pt_next.y   = sat_y.val;
            pt_next.sat = pt6_reg.sat | sat_x.clip | sat_y.clip;
        end
        else
        begin
            pt_next = pt6_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= 33'(in_pt.x) - 33'(ox);
        dy_reg   <= 33'(in_pt.y) - 33'(oy);
        pt4_reg  <= in_pt;
        xc_reg   <= dx_reg * trig.cos_val;
        ys_reg   <= dy_reg * trig.sin_val;
        xs_reg   <= dx_reg * trig.sin_val;
        yc_reg   <= dy_reg * trig.cos_val;
        pt5_reg  <= pt4_reg;
        sumx_reg <= 66'(xc_reg) - 66'(ys_reg);
        sumy_reg <= 66'(xs_reg) + 66'(yc_reg);
        pt6_reg  <= pt5_reg;
        pt7_reg  <= pt_next;
    end

    assign out_valid = v7_reg;
    assign out_pt    = pt7_reg;

endmodule
